FILE: sv/bir_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the bilinear image resizer
// no dependencies

package bir_pkg;

  localparam int NUM_CH    = 3;
  localparam int CH_W      = 8;
  localparam int PIX_W     = NUM_CH * CH_W;
  localparam int SIZE_W    = 9;
  localparam int STEP_W    = 25;
  localparam int CNT_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 25;
  localparam int POS_W     = 8;
  localparam int PROD_W    = POS_W + STEP_W;
  localparam int IPOS_W    = PROD_W - 16;
  localparam int WT_W      = 9;
  localparam int WPROD_W   = 17;
  localparam int TERM_W    = WPROD_W + CH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_X_STEP     = 3'd4,
    CFG_Y_STEP     = 3'd5,
    CFG_CH_COUNT   = 3'd6
  } cfg_idx_t;

  localparam int MODE_LOAD    = 0;
  localparam int MODE_PRODUCE = 1;

  // strobes from the sequencer to the blend datapath
  typedef struct packed {
    logic wts;   // form the four corner weights
    logic cap;   // capture top row samples
    logic mul;   // multiply samples by weights
  } blend_ctl_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_AXIS = 6'b000010,
    S_RD0  = 6'b000100,
    S_RD1  = 6'b001000,
    S_MUL  = 6'b010000,
    S_SUM  = 6'b100000
  } state_t;

endpackage

FILE: sv/bir_in_if.sv
`timescale 1ns / 1ps
// input channel of the resizer: load or produce requests
// depends on bir_pkg

interface bir_in_if import bir_pkg::*;;
  logic            valid;
  logic            ready;
  logic            mode;
  logic [CH_W-1:0] in_chan0;
  logic [CH_W-1:0] in_chan1;
  logic [CH_W-1:0] in_chan2;

  modport source (output valid, mode, in_chan0, in_chan1, in_chan2, input ready);
  modport sink   (input valid, mode, in_chan0, in_chan1, in_chan2, output ready);
endinterface

FILE: sv/bir_out_if.sv
`timescale 1ns / 1ps
// result channel of the resizer: one interpolated pixel per beat
// depends on bir_pkg

interface bir_out_if import bir_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_chan0;
  logic [CH_W-1:0]  out_chan1;
  logic [CH_W-1:0]  out_chan2;
  logic [POS_W-1:0] pixel_row;
  logic [POS_W-1:0] pixel_col;
  logic             frame_last;

  modport source (output valid, out_chan0, out_chan1, out_chan2, pixel_row, pixel_col,
                  frame_last, input ready);
  modport sink   (input valid, out_chan0, out_chan1, out_chan2, pixel_row, pixel_col,
                  frame_last, output ready);
endinterface

FILE: sv/bir_frame_store.sv
`timescale 1ns / 1ps
// frame store: one write port, two read ports, registered read data
// depends on bir_pkg

module bir_frame_store import bir_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [PIX_W-1:0] rdata0,
  output logic [PIX_W-1:0] rdata1
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: sv/bir_axis.sv
`timescale 1ns / 1ps
// one axis: integer source index and 9-bit weight from the scaled position
// depends on bir_pkg

module bir_axis import bir_pkg::*; #(
  parameter int IW  = 8,
  parameter int SZW = 9
) (
  input  logic [PROD_W-1:0] pos,
  input  logic [SZW-1:0]    size,
  output logic [IW-1:0]     base,
  output logic [WT_W-1:0]   wt
);

  logic [IPOS_W-1:0] ip;
  logic [IPOS_W-1:0] lim;
  logic              edge_hit;
  logic [SZW-1:0]    size_m2;

  assign ip       = pos[PROD_W-1:16];
  assign lim      = IPOS_W'(size) - IPOS_W'(1);
  assign edge_hit = ip >= lim;
  assign size_m2  = size - SZW'(2);

  // at the last column or row the pair sits at size minus two, full weight
  assign base = edge_hit ? IW'(size_m2) : IW'(ip);
  assign wt   = edge_hit ? WT_W'(256) : {1'b0, pos[15:8]};

endmodule

FILE: sv/bir_blend.sv
`timescale 1ns / 1ps
// blend datapath: corner weights, per-channel products, sum and truncation
// depends on bir_pkg

module bir_blend import bir_pkg::*; (
  input  logic                        clk,
  input  blend_ctl_t                  ctl,
  input  logic [WT_W-1:0]             u,
  input  logic [WT_W-1:0]             v,
  input  logic [PIX_W-1:0]            rd0,
  input  logic [PIX_W-1:0]            rd1,
  input  logic [CNT_W-1:0]            nch,
  output logic [NUM_CH-1:0][CH_W-1:0] chan
);

  logic [WT_W-1:0]                       nu;
  logic [WT_W-1:0]                       nv;
  logic [3:0][WPROD_W-1:0]               w_r;
  logic [1:0][PIX_W-1:0]                 top_r;

  assign nu = WT_W'(256) - u;
  assign nv = WT_W'(256) - v;

  // corner order: 00, 01 (right), 10 (below), 11
  always_ff @(posedge clk) begin
    if (ctl.wts) begin
      w_r[0] <= WPROD_W'(nu) * WPROD_W'(nv);
      w_r[1] <= WPROD_W'(u) * WPROD_W'(nv);
      w_r[2] <= WPROD_W'(nu) * WPROD_W'(v);
      w_r[3] <= WPROD_W'(u) * WPROD_W'(v);
    end
    if (ctl.cap) begin
      top_r[0] <= rd0;
      top_r[1] <= rd1;
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_ch
    logic [3:0][TERM_W-1:0] prod_r;
    logic [TERM_W+1:0]      sum;

    always_ff @(posedge clk) begin
      if (ctl.mul) begin
        prod_r[0] <= TERM_W'(w_r[0]) * TERM_W'(top_r[0][k*CH_W +: CH_W]);
        prod_r[1] <= TERM_W'(w_r[1]) * TERM_W'(top_r[1][k*CH_W +: CH_W]);
        prod_r[2] <= TERM_W'(w_r[2]) * TERM_W'(rd0[k*CH_W +: CH_W]);
        prod_r[3] <= TERM_W'(w_r[3]) * TERM_W'(rd1[k*CH_W +: CH_W]);
      end
    end

    assign sum = (TERM_W+2)'(prod_r[0]) + (TERM_W+2)'(prod_r[1])
               + (TERM_W+2)'(prod_r[2]) + (TERM_W+2)'(prod_r[3]);
    assign chan[k] = (CNT_W'(k) < nch) ? sum[23:16] : '0;
  end

endmodule

FILE: sv/bilinear_image_resize.sv
`timescale 1ns / 1ps
// channel    dir  beat contents
// in_port    in   mode, in_chan0..2       (mode 0 load pixel, mode 1 produce)
// out_port   out  out_chan0..2, pixel_row, pixel_col, frame_last
// cfg_*      in   cfg_we, cfg_index, cfg_data (write only)
//
// a load beat is written straight into the frame store when it is taken.
// a produce beat steps through multiply, axis, two reads on the
// two-port frame store for the four neighbours, product and sum.
// the output register lets the next beat be taken while a pixel waits.
// rst_n is synchronous; the frame store itself has no reset.
// depends on bir_pkg, bir_in_if, bir_out_if, bir_frame_store, bir_axis, bir_blend

module bilinear_image_resize import bir_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bir_in_if.sink               in_port,
  bir_out_if.source            out_port,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int SWW   = $clog2(MAX_WIDTH + 1);
  localparam int SHW   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [SIZE_W-1:0] src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [STEP_W-1:0] x_step_r, y_step_r;
  logic [CNT_W-1:0]  ch_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIZE_W'(256);
      src_height_r <= SIZE_W'(256);
      dst_width_r  <= SIZE_W'(32);
      dst_height_r <= SIZE_W'(32);
      x_step_r     <= STEP_W'(524288);
      y_step_r     <= STEP_W'(524288);
      ch_count_r   <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[SIZE_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_data[SIZE_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_data[SIZE_W-1:0];
        CFG_X_STEP:     x_step_r     <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:     y_step_r     <= cfg_data[STEP_W-1:0];
        CFG_CH_COUNT:   ch_count_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [SWW-1:0]    sw;
  logic [SHW-1:0]    sh;
  logic [SIZE_W-1:0] dw, dh;
  logic [CNT_W-1:0]  nch;

  always_comb begin
    if (src_width_r < SIZE_W'(2)) begin
      sw = SWW'(2);
    end else if (32'(src_width_r) > 32'(MAX_WIDTH)) begin
      sw = SWW'(MAX_WIDTH);
    end else begin
      sw = SWW'(src_width_r);
    end
    if (src_height_r < SIZE_W'(2)) begin
      sh = SHW'(2);
    end else if (32'(src_height_r) > 32'(MAX_HEIGHT)) begin
      sh = SHW'(MAX_HEIGHT);
    end else begin
      sh = SHW'(src_height_r);
    end
    if (dst_width_r == '0) begin
      dw = SIZE_W'(1);
    end else if (dst_width_r > SIZE_W'(256)) begin
      dw = SIZE_W'(256);
    end else begin
      dw = dst_width_r;
    end
    if (dst_height_r == '0) begin
      dh = SIZE_W'(1);
    end else if (dst_height_r > SIZE_W'(256)) begin
      dh = SIZE_W'(256);
    end else begin
      dh = dst_height_r;
    end
    nch = (ch_count_r == '0) ? CNT_W'(1) : ch_count_r;
  end

  // sequencer
  state_t state_r, state_nxt;
  logic   in_acc, load_beat, prod_beat, out_free;

  assign in_port.ready = (state_r == S_IDLE);
  assign in_acc        = in_port.valid && in_port.ready;
  assign load_beat     = in_acc && (in_port.mode == 1'(MODE_LOAD));
  assign prod_beat     = in_acc && (in_port.mode == 1'(MODE_PRODUCE));

  logic out_valid_r;
  assign out_free = !out_valid_r || out_port.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (prod_beat) state_nxt = S_AXIS;
      S_AXIS: state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // load position
  logic [YW-1:0]  load_row_r, load_row_nxt, lr_cur;
  logic [XW-1:0]  load_col_r, load_col_nxt, lc_cur;
  logic [SWW-1:0] lc_inc;
  logic [SHW-1:0] lr_inc;

  always_comb begin
    lr_cur       = (SHW'(load_row_r) < sh) ? load_row_r : '0;
    lc_cur       = (SWW'(load_col_r) < sw) ? load_col_r : '0;
    lc_inc       = SWW'(lc_cur) + SWW'(1);
    lr_inc       = SHW'(lr_cur) + SHW'(1);
    load_row_nxt = lr_cur;
    load_col_nxt = XW'(lc_inc);
    if (lc_inc >= sw) begin
      load_col_nxt = '0;
      load_row_nxt = (lr_inc >= sh) ? '0 : YW'(lr_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
    end else if (load_beat) begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
    end
  end

  // emit position
  logic [POS_W-1:0]  emit_row_r, emit_row_nxt, emit_col_r, emit_col_nxt;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic              last_px;
  logic              emit_done;

  assign emit_done = (state_r == S_SUM) && out_free;

  always_comb begin
    col_inc      = SIZE_W'(emit_col_r) + SIZE_W'(1);
    row_inc      = SIZE_W'(emit_row_r) + SIZE_W'(1);
    emit_col_nxt = POS_W'(col_inc);
    emit_row_nxt = emit_row_r;
    if (col_inc >= dw) begin
      emit_col_nxt = '0;
      emit_row_nxt = (row_inc >= dh) ? '0 : POS_W'(row_inc);
    end
    last_px = (SIZE_W'(emit_row_r) >= dh - SIZE_W'(1))
           && (SIZE_W'(emit_col_r) >= dw - SIZE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else if (emit_done) begin
      emit_row_r <= emit_row_nxt;
      emit_col_r <= emit_col_nxt;
    end
  end

  // scaled positions, then index and weight per axis
  logic [PROD_W-1:0] px_r, py_r;
  logic [XW-1:0]     x_base;
  logic [YW-1:0]     y_base;
  logic [WT_W-1:0]   u_wt, v_wt, u_r, v_r;
  logic [AW-1:0]     addr_r;

  always_ff @(posedge clk) begin
    if (prod_beat) begin
      px_r <= PROD_W'(emit_col_r) * PROD_W'(x_step_r);
      py_r <= PROD_W'(emit_row_r) * PROD_W'(y_step_r);
    end
    if (state_r == S_AXIS) begin
      u_r    <= u_wt;
      v_r    <= v_wt;
      addr_r <= AW'(y_base) * AW'(MAX_WIDTH) + AW'(x_base);
    end
  end

  bir_axis #(.IW(XW), .SZW(SWW)) u_axis_x (
    .pos(px_r), .size(sw), .base(x_base), .wt(u_wt)
  );

  bir_axis #(.IW(YW), .SZW(SHW)) u_axis_y (
    .pos(py_r), .size(sh), .base(y_base), .wt(v_wt)
  );

  // frame store: top pair read in S_RD0, bottom pair in S_RD1
  logic [AW-1:0]    waddr, raddr0, raddr1;
  logic [PIX_W-1:0] wdata, rdata0, rdata1;

  assign waddr  = AW'(lr_cur) * AW'(MAX_WIDTH) + AW'(lc_cur);
  assign wdata  = {in_port.in_chan2, in_port.in_chan1, in_port.in_chan0};
  assign raddr0 = (state_r == S_RD1) ? addr_r + AW'(MAX_WIDTH) : addr_r;
  assign raddr1 = raddr0 + AW'(1);

  bir_frame_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(load_beat), .waddr(waddr), .wdata(wdata),
    .raddr0(raddr0), .raddr1(raddr1), .rdata0(rdata0), .rdata1(rdata1)
  );

  blend_ctl_t                  bctl;
  logic [NUM_CH-1:0][CH_W-1:0] chan;

  assign bctl.wts = (state_r == S_RD0);
  assign bctl.cap = (state_r == S_RD1);
  assign bctl.mul = (state_r == S_MUL);

  bir_blend u_blend (
    .clk(clk), .ctl(bctl), .u(u_r), .v(v_r),
    .rd0(rdata0), .rd1(rdata1), .nch(nch), .chan(chan)
  );

  // output register
  logic [CH_W-1:0]  oc0_r, oc1_r, oc2_r;
  logic [POS_W-1:0] orow_r, ocol_r;
  logic             olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_done) begin
      out_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_done) begin
      oc0_r   <= chan[0];
      oc1_r   <= chan[1];
      oc2_r   <= chan[2];
      orow_r  <= emit_row_r;
      ocol_r  <= emit_col_r;
      olast_r <= last_px;
    end
  end

  assign out_port.valid      = out_valid_r;
  assign out_port.out_chan0  = oc0_r;
  assign out_port.out_chan1  = oc1_r;
  assign out_port.out_chan2  = oc2_r;
  assign out_port.pixel_row  = orow_r;
  assign out_port.pixel_col  = ocol_r;
  assign out_port.frame_last = olast_r;

endmodule
